[hdl/szs_pkg.sv]
// Shared types, constants and helpers for the sample zone selector.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package szs_pkg;

  // Table capacity and derived widths
  localparam int unsigned MAX_ZONES = 16;
  localparam int unsigned CNT_W     = $clog2(MAX_ZONES + 1);
  localparam int unsigned IDX_W     = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned ZIDX_W    = 4;

  // Distance value that no real gap reaches
  localparam logic [NOTE_W:0] NO_DISTANCE = 8'd128;

  // Command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_APPEND = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic              command;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] velocity;
    logic [NOTE_W-1:0] zone_root;
    logic [NOTE_W-1:0] zone_vel_low;
    logic [NOTE_W-1:0] zone_vel_high;
  } szs_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ZIDX_W-1:0] zone_index;
    logic [NOTE_W-1:0] distance;
    logic              velocity_hit;
  } szs_out_t;

  typedef struct packed {
    logic [NOTE_W-1:0] root;
    logic [NOTE_W-1:0] vel_low;
    logic [NOTE_W-1:0] vel_high;
  } zone_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN_VEL,
    ST_SCAN_ALL,
    ST_HIT,
    ST_NEAR,
    ST_NONE
  } szs_state_e;

  typedef enum logic [2:0] {
    KIND_APPEND,
    KIND_FULL,
    KIND_NONE,
    KIND_HIT,
    KIND_NEAR
  } szs_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    logic      restart;
    logic      scan;
    logic      use_vel;
    logic      append_write;
    logic      load_out;
    szs_kind_e kind;
  } szs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic table_empty;
    logic table_full;
    logic scan_done;
    logic found;
    logic out_free;
  } szs_stat_t;

  // Low bits of a table index, zero-extended when the index is narrower
  function automatic logic [ZIDX_W-1:0] to_zone_index(input logic [CNT_W-1:0] idx);
    logic [CNT_W+ZIDX_W-1:0] wide;
    wide = {{ZIDX_W{1'b0}}, idx};
    return wide[ZIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/szs_ctrl.sv]
// Sequencing state machine of the sample zone selector.
// Depends on szs_pkg; drives szs_datapath through szs_cmd_t.
`default_nettype none

module szs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_command_i,
  output logic                   in_stall_o,
  input  wire szs_pkg::szs_stat_t stat_i,
  output szs_pkg::szs_cmd_t      cmd_o
);

  szs_pkg::szs_state_e state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != szs_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == szs_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= szs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      szs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_command_i == szs_pkg::CMD_APPEND) begin
            state_d = szs_pkg::ST_APPEND;
          end else if (stat_i.table_empty) begin
            state_d = szs_pkg::ST_NONE;
          end else begin
            state_d = szs_pkg::ST_SCAN_VEL;
          end
        end
      end
      szs_pkg::ST_SCAN_VEL: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.found ? szs_pkg::ST_HIT : szs_pkg::ST_SCAN_ALL;
        end
      end
      szs_pkg::ST_SCAN_ALL: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.found ? szs_pkg::ST_NEAR : szs_pkg::ST_NONE;
        end
      end
      szs_pkg::ST_APPEND,
      szs_pkg::ST_HIT,
      szs_pkg::ST_NEAR,
      szs_pkg::ST_NONE: begin
        if (stat_i.out_free) begin
          state_d = szs_pkg::ST_IDLE;
        end
      end
      default: state_d = szs_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o              = '0;
    cmd_o.kind         = szs_pkg::KIND_NONE;
    cmd_o.capture      = accept;
    unique case (state_q)
      szs_pkg::ST_IDLE: ;
      szs_pkg::ST_SCAN_VEL: begin
        cmd_o.use_vel = 1'b1;
        cmd_o.scan    = !stat_i.scan_done;
        cmd_o.restart = stat_i.scan_done && !stat_i.found;
      end
      szs_pkg::ST_SCAN_ALL: begin
        cmd_o.scan = !stat_i.scan_done;
      end
      szs_pkg::ST_APPEND: begin
        cmd_o.kind         = stat_i.table_full ? szs_pkg::KIND_FULL : szs_pkg::KIND_APPEND;
        cmd_o.load_out     = stat_i.out_free;
        cmd_o.append_write = stat_i.out_free && !stat_i.table_full;
      end
      szs_pkg::ST_HIT: begin
        cmd_o.kind     = szs_pkg::KIND_HIT;
        cmd_o.load_out = stat_i.out_free;
      end
      szs_pkg::ST_NEAR: begin
        cmd_o.kind     = szs_pkg::KIND_NEAR;
        cmd_o.load_out = stat_i.out_free;
      end
      szs_pkg::ST_NONE: begin
        cmd_o.kind     = szs_pkg::KIND_NONE;
        cmd_o.load_out = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/szs_datapath.sv]
// Zone table, scan unit and result register of the sample zone selector.
// Depends on szs_pkg; steered by szs_ctrl through szs_cmd_t.
`default_nettype none

module szs_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire szs_pkg::szs_in_t   in_data_i,
  input  wire szs_pkg::szs_cmd_t  cmd_i,
  output szs_pkg::szs_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output szs_pkg::szs_out_t       out_data_o
);

  szs_pkg::zone_entry_t zone_mem [szs_pkg::MAX_ZONES];

  szs_pkg::szs_in_t     item_q;
  logic [szs_pkg::CNT_W-1:0]  count_q;
  logic [szs_pkg::CNT_W-1:0]  rd_addr_q;
  logic [szs_pkg::CNT_W-1:0]  cmp_idx_q;
  szs_pkg::zone_entry_t rd_data_q;
  logic                 pend_q;
  logic [szs_pkg::NOTE_W:0]   best_dist_q;
  logic [szs_pkg::CNT_W-1:0]  best_idx_q;
  logic                 found_q;
  logic                 out_valid_q;
  szs_pkg::szs_out_t    out_q, out_d;

  logic                 issue;
  logic                 in_range;
  logic [szs_pkg::NOTE_W-1:0] gap;
  logic                 better;
  szs_pkg::zone_entry_t new_entry;

  assign issue    = rd_addr_q < count_q;
  assign in_range = (item_q.velocity >= rd_data_q.vel_low) &&
                    (item_q.velocity <= rd_data_q.vel_high);
  assign gap      = (item_q.note >= rd_data_q.root) ? (item_q.note - rd_data_q.root)
                                                   : (rd_data_q.root - item_q.note);
  assign better   = pend_q && (!cmd_i.use_vel || in_range) && ({1'b0, gap} < best_dist_q);

  assign new_entry = '{root:     item_q.zone_root,
                       vel_low:  item_q.zone_vel_low,
                       vel_high: item_q.zone_vel_high};

  assign stat_o.table_empty = (count_q == '0);
  assign stat_o.table_full  = (count_q == szs_pkg::CNT_W'(szs_pkg::MAX_ZONES));
  assign stat_o.scan_done   = !issue && !pend_q;
  assign stat_o.found       = found_q;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  // Hold the accepted item for the whole operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_write) begin
      zone_mem[count_q[szs_pkg::IDX_W-1:0]] <= new_entry;
    end
    if (cmd_i.scan && issue) begin
      rd_data_q <= zone_mem[rd_addr_q[szs_pkg::IDX_W-1:0]];
      cmp_idx_q <= rd_addr_q;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.append_write) begin
      count_q <= count_q + 1'b1;
    end
  end

  // Scan address, compare stage and running best
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      pend_q      <= 1'b0;
      best_dist_q <= szs_pkg::NO_DISTANCE;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
    end else if (cmd_i.capture || cmd_i.restart) begin
      rd_addr_q   <= '0;
      pend_q      <= 1'b0;
      best_dist_q <= szs_pkg::NO_DISTANCE;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan) begin
      if (issue) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
      pend_q <= issue;
      if (better) begin
        best_dist_q <= {1'b0, gap};
        best_idx_q  <= cmp_idx_q;
        found_q     <= 1'b1;
      end
    end
  end

  // Result formatting
  always_comb begin
    out_d = '0;
    unique case (cmd_i.kind)
      szs_pkg::KIND_APPEND: begin
        out_d.status     = szs_pkg::STATUS_OK;
        out_d.zone_index = szs_pkg::to_zone_index(count_q);
      end
      szs_pkg::KIND_FULL: out_d.status = szs_pkg::STATUS_FULL;
      szs_pkg::KIND_NONE: out_d.status = szs_pkg::STATUS_NOT_FOUND;
      szs_pkg::KIND_HIT, szs_pkg::KIND_NEAR: begin
        out_d.status       = szs_pkg::STATUS_OK;
        out_d.zone_index   = szs_pkg::to_zone_index(best_idx_q);
        out_d.distance     = best_dist_q[szs_pkg::NOTE_W-1:0];
        out_d.velocity_hit = (cmd_i.kind == szs_pkg::KIND_HIT);
      end
      default: out_d.status = szs_pkg::STATUS_NOT_FOUND;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hdl/sample_zone_selector.sv]
// Sample zone selector: appends zones to a table and picks the best zone per note.
// Appends, full-table beats and lookups on an empty table skip the scan; any other
//   lookup scans the N stored zones one entry per cycle over the single read port
//   of the zone table.
// Throughput: one beat per operation; a new beat is taken once the result is loaded.
// Reset: asynchronous, active low; empties the table and clears all control state.
`default_nettype none

module sample_zone_selector (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire szs_pkg::szs_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output szs_pkg::szs_out_t     out_data_o
);

  // Command and status between the sequencer and the datapath
  szs_pkg::szs_cmd_t  cmd;
  szs_pkg::szs_stat_t stat;

  // Sequencer: takes one beat at a time; a lookup runs the velocity pass and, if that
  // finds nothing, the note-only pass; then it waits for room in the output register.
  szs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Datapath: zone table, scan compare and result register. The result register
  // lets the next beat be taken while the previous result still waits downstream.
  szs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/szs_chk.sv]
// Port-level checks for the sample zone selector, bound to its top level.
// Depends on szs_pkg.
`default_nettype none

module szs_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire szs_pkg::szs_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire szs_pkg::szs_out_t out_data_o
);

  // A taken beat blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == szs_pkg::STATUS_OK ||
                     out_data_o.status == szs_pkg::STATUS_NOT_FOUND ||
                     out_data_o.status == szs_pkg::STATUS_FULL))
    else $error("illegal status code");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != szs_pkg::STATUS_OK) |->
      (out_data_o.zone_index == '0 && out_data_o.distance == '0 &&
       !out_data_o.velocity_hit))
    else $error("failed result carries nonzero fields");

  a_hit_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.velocity_hit) |-> (out_data_o.status == szs_pkg::STATUS_OK))
    else $error("velocity hit with failing status");

endmodule

bind sample_zone_selector szs_chk u_szs_chk (.*);

`default_nettype wire

[dv/sample_zone_selector_tb.sv]
// Self-checking testbench for sample_zone_selector: directed beats, then random traffic.
// Depends on szs_pkg (beat types, command and status codes) and the block's RTL only.
`timescale 1ns / 1ps

module sample_zone_selector_tb;
  import szs_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1500;
  localparam int unsigned DRAIN_CYCLES = 40;  // longest lookup plus margin

  typedef struct {
    szs_in_t  beat;
    bit       typed;  // res holds a hand-written expectation
    szs_out_t res;
  } plan_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  szs_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  szs_out_t out_data_o;

  // Mirror of the zone table as the predictor sees it
  zone_entry_t zone_mirror [MAX_ZONES];
  int unsigned zone_fill = 0;

  szs_out_t    expected_picks [$];
  szs_out_t    want_pick;
  int unsigned fault_count = 0;
  bit          calm_sender = 1'b0;

  sample_zone_selector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Predict the result of one accepted beat and advance the mirrored table.
  task automatic pick_zone(input szs_in_t beat, output szs_out_t res);
    logic [NOTE_W:0] best;
    logic [NOTE_W:0] gap;
    int unsigned     pick;
    int unsigned     pass;
    int unsigned     i;
    bit              found;
    bit              hit;
    zone_entry_t     z;
    res   = '0;
    best  = NO_DISTANCE;
    pick  = 0;
    found = 1'b0;
    hit   = 1'b0;
    res.status = STATUS_OK;
    if (beat.command == CMD_APPEND) begin
      if (zone_fill >= MAX_ZONES) begin
        res.status = STATUS_FULL;
      end else begin
        zone_mirror[zone_fill].root     = beat.zone_root;
        zone_mirror[zone_fill].vel_low  = beat.zone_vel_low;
        zone_mirror[zone_fill].vel_high = beat.zone_vel_high;
        res.zone_index = zone_fill[ZIDX_W-1:0];
        zone_fill++;
      end
    end else if (zone_fill == 0) begin
      res.status = STATUS_NOT_FOUND;
    end else begin
      // First pass honors the velocity ranges; the second, by note alone,
      // runs only when no range held the velocity.
      for (pass = 0; pass < 2; pass++) begin
        if (!found) begin
          for (i = 0; i < zone_fill; i++) begin
            z = zone_mirror[i];
            if (pass == 0 && (beat.velocity < z.vel_low || beat.velocity > z.vel_high))
              continue;
            gap = {1'b0, (beat.note >= z.root) ? beat.note - z.root : z.root - beat.note};
            if (gap < best) begin
              best  = gap;
              pick  = i;
              found = 1'b1;
              hit   = (pass == 0);
            end
          end
        end
      end
      res.zone_index   = pick[ZIDX_W-1:0];
      res.distance     = best[NOTE_W-1:0];
      res.velocity_hit = hit;
    end
  endtask

  function automatic plan_row_t mk_row(logic cmd, int note, int vel, int root, int lo,
                                       int hi, bit typed, logic [1:0] st, int idx);
    plan_row_t r;
    r.beat.command       = cmd;
    r.beat.note          = note[NOTE_W-1:0];
    r.beat.velocity      = vel[NOTE_W-1:0];
    r.beat.zone_root     = root[NOTE_W-1:0];
    r.beat.zone_vel_low  = lo[NOTE_W-1:0];
    r.beat.zone_vel_high = hi[NOTE_W-1:0];
    r.typed              = typed;
    r.res                = '0;
    r.res.status         = st;
    r.res.zone_index     = idx[ZIDX_W-1:0];
    return r;
  endfunction

  function automatic int clamp7(int v);
    return (v < 0) ? 0 : ((v > 127) ? 127 : v);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Offer one beat, hold it until taken, then record what it must produce.
  task automatic offer_beat(input plan_row_t row);
    szs_out_t    res;
    int unsigned gap;
    gap = 0;
    if (!calm_sender && $urandom_range(99) < 24)
      gap = $urandom_range(1, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= row.beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pick_zone(row.beat, res);
    if (row.typed)
      res = row.res;
    expected_picks.push_back(res);
  endtask

  // Result side: compare every accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        fault_count++;
      end else begin
        want_pick = expected_picks.pop_front();
        check_field("status", 8'(want_pick.status), 8'(out_data_o.status));
        check_field("zone_index", 8'(want_pick.zone_index), 8'(out_data_o.zone_index));
        check_field("distance", 8'(want_pick.distance), 8'(out_data_o.distance));
        check_field("velocity_hit", 8'(want_pick.velocity_hit),
                    8'(out_data_o.velocity_hit));
      end
    end
  end

  // Result side stall: random, one long hold-off to back the block up,
  // and a calm window with no stall at all.
  initial begin : drain_side
    int unsigned cyc;
    int unsigned hold;
    cyc  = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 5000)
        hold = 300;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else if (cyc >= 30000 && cyc < 40000) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 24);
      end
    end
  end

  initial begin : watchdog
    #(10_000_000);
    $display("sample_zone_selector_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   zone_plan [$];
    plan_row_t   row;
    logic [63:0] raw_bits;
    int unsigned n;
    int unsigned k;
    int unsigned j;
    int          note;
    int          vel;

    // Empty lookup, first zone and two lookups on it, then fill the table up with a mix of
    // extremes, an inverted range, duplicate roots and velocity holes
    // (41..44 and 96..99 are held by no zone).
    zone_plan.push_back(mk_row(CMD_LOOKUP, 60, 100, 0, 0, 0, 1, STATUS_NOT_FOUND, 0));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 60, 20, 40, 1, STATUS_OK, 0));
    zone_plan.push_back(mk_row(CMD_LOOKUP, 127, 127, 0, 0, 0, 0, STATUS_OK, 0));
    zone_plan.push_back(mk_row(CMD_LOOKUP, 0, 30, 127, 127, 127, 0, STATUS_OK, 0));
    zone_plan.push_back(mk_row(CMD_APPEND, 127, 127, 0, 0, 0, 1, STATUS_OK, 1));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 127, 127, 127, 1, STATUS_OK, 2));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 64, 90, 40, 1, STATUS_OK, 3));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 64, 20, 20, 1, STATUS_OK, 4));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 60, 30, 35, 1, STATUS_OK, 5));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 30, 1, 19, 1, STATUS_OK, 6));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 90, 50, 60, 1, STATUS_OK, 7));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 10, 110, 5, 1, STATUS_OK, 8));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 100, 64, 64, 1, STATUS_OK, 9));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 45, 0, 15, 1, STATUS_OK, 10));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 75, 61, 95, 1, STATUS_OK, 11));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 20, 100, 126, 1, STATUS_OK, 12));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 110, 45, 55, 1, STATUS_OK, 13));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 5, 120, 127, 1, STATUS_OK, 14));
    zone_plan.push_back(mk_row(CMD_APPEND, 0, 0, 120, 10, 30, 1, STATUS_OK, 15));
    // Table is full now: the append is refused
    zone_plan.push_back(mk_row(CMD_APPEND, 127, 127, 127, 127, 127, 1, STATUS_FULL, 0));
    zone_plan.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, STATUS_OK, 0));
    zone_plan.push_back(mk_row(CMD_LOOKUP, 127, 127, 0, 0, 0, 0, STATUS_OK, 0));
    // Tie between zones 0 and 5: lower index wins
    zone_plan.push_back(mk_row(CMD_LOOKUP, 60, 32, 0, 0, 0, 0, STATUS_OK, 0));
    // Velocity in a hole: note-only fallback, inverted zone 3 ties with zone 4
    zone_plan.push_back(mk_row(CMD_LOOKUP, 64, 42, 0, 0, 0, 0, STATUS_OK, 0));
    zone_plan.push_back(mk_row(CMD_LOOKUP, 64, 20, 0, 0, 0, 0, STATUS_OK, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (zone_plan[p])
      offer_beat(zone_plan[p]);

    // Random part: mostly lookups, some aimed near roots, midpoints and range
    // edges; appends keep probing the full table with random content.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      calm_sender = (n >= 700 && n < 900);
      raw_bits  = {$urandom, $urandom};
      row.beat  = raw_bits[$bits(szs_in_t)-1:0];
      row.typed = 1'b0;
      row.res   = '0;
      row.beat.command = ($urandom_range(99) < 15) ? CMD_APPEND : CMD_LOOKUP;
      if (row.beat.command == CMD_LOOKUP) begin
        k = $urandom_range(zone_fill - 1);
        j = $urandom_range(zone_fill - 1);
        case ($urandom_range(9))
          6, 7:    note = clamp7(int'(zone_mirror[k].root) + $urandom_range(6) - 3);
          8, 9:    note = (int'(zone_mirror[k].root) + int'(zone_mirror[j].root)) / 2;
          default: note = $urandom_range(127);
        endcase
        if ($urandom_range(9) >= 7) begin
          vel = $urandom_range(1) ? int'(zone_mirror[j].vel_low) : int'(zone_mirror[j].vel_high);
          vel = clamp7(vel + $urandom_range(2) - 1);
        end else begin
          vel = $urandom_range(127);
        end
        row.beat.note     = note[NOTE_W-1:0];
        row.beat.velocity = vel[NOTE_W-1:0];
      end
      offer_beat(row);
    end
    in_valid_i <= 1'b0;

    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("sample_zone_selector_tb OK");
    end else begin
      $display("sample_zone_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/szs_pkg.sv
hdl/szs_ctrl.sv
hdl/szs_datapath.sv
hdl/sample_zone_selector.sv
hdl/szs_chk.sv
dv/sample_zone_selector_tb.sv
